// ===== sv/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP pixel unpacker package
// Shared constants, codes, request struct and helpers for the unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

    // Image limits and default palette size.
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;

    // Field and counter widths.
    localparam int DIM_W = 13;   // width/height register, column counter
    localparam int POS_W = 12;   // column and row on the output
    localparam int RBC_W = 14;   // bytes seen in the current row
    localparam int DB_W  = 15;   // byte counts per row
    localparam int RGB_W = 24;

    // Pixel formats.
    typedef enum logic [1:0] {
        FMT_1BPP  = 2'd0,
        FMT_4BPP  = 2'd1,
        FMT_8BPP  = 2'd2,
        FMT_24BPP = 2'd3
    } t_fmt;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FORMAT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    // Input item kinds.
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    // One pixel on its way from the unpacker to the output stage.
    typedef struct packed {
        logic             direct;    // 24-bit pixel, color carried in rgb
        logic             in_range;  // palette index lies inside the store
        logic [RGB_W-1:0] rgb;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
        logic             eoi;
    } t_pix_req;

    // A zero dimension counts as one; larger values saturate at the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== sv/bpu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bpu_unpack.sv =====
// ----------------------------------------------------------------------------
// BMP unpacker front end
// Holds one input beat, walks its pixels one per cycle while the next
// stage is free, keeps the row counters, issues palette reads and writes.
// ----------------------------------------------------------------------------
module bpu_unpack #(
    parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bpu_pkg::t_fmt                    i_fmt,
    input  logic [bpu_pkg::DIM_W-1:0]        i_width,
    input  logic [bpu_pkg::DIM_W-1:0]        i_height,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic [7:0]                       i_data_byte,
    input  logic [7:0]                       i_entry_index,
    input  logic [7:0]                       i_entry_red,
    input  logic [7:0]                       i_entry_green,
    input  logic [7:0]                       i_entry_blue,
    input  logic                             i_s2_free,
    output logic                             o_req_valid,
    output bpu_pkg::t_pix_req                o_req,
    output logic [$clog2(PALETTE_DEPTH)-1:0] o_rd_addr,
    output logic                             o_wr_en,
    output logic [$clog2(PALETTE_DEPTH)-1:0] o_wr_addr,
    output logic [bpu_pkg::RGB_W-1:0]        o_wr_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    // Held input beat.
    logic       r_s1_valid;
    logic       r_kind;
    logic [7:0] r_byte;
    logic [7:0] r_eidx;
    logic [7:0] r_er;
    logic [7:0] r_eg;
    logic [7:0] r_eb;
    logic [2:0] r_sub;

    // Row position state.
    logic [bpu_pkg::DIM_W-1:0] r_col, n_col;
    logic [bpu_pkg::POS_W-1:0] r_row, n_row;
    logic [bpu_pkg::RBC_W-1:0] r_rbc, n_rbc;
    logic [1:0]                r_phase, n_phase;
    logic [7:0]                r_blue, n_blue;
    logic [7:0]                r_green, n_green;

    logic [bpu_pkg::DIM_W-1:0] w;
    logic [bpu_pkg::DIM_W-1:0] h;
    logic [bpu_pkg::DB_W-1:0]  w_ext;
    logic [bpu_pkg::DB_W-1:0]  db;
    logic [bpu_pkg::DB_W-1:0]  padded;
    logic [bpu_pkg::DB_W-1:0]  rbc_inc;
    logic [bpu_pkg::DIM_W-1:0] col_inc;
    logic [bpu_pkg::DIM_W-1:0] row_inc;
    logic                      is_pix;
    logic                      active;
    logic                      col_lt_w;
    logic                      col_end;
    logic                      row_end;
    logic                      row_wrap;
    logic                      per_last;
    logic                      emit;
    logic                      done;
    logic                      step;
    logic                      accept;
    logic                      eoi;
    logic [7:0]                idx;

    // Clamped dimensions and the padded row length in bytes.
    always_comb begin
        w     = bpu_pkg::clamp_dim(i_width, bpu_pkg::DIM_W'(bpu_pkg::MAX_WIDTH));
        h     = bpu_pkg::clamp_dim(i_height, bpu_pkg::DIM_W'(bpu_pkg::MAX_HEIGHT));
        w_ext = {2'b00, w};
        case (i_fmt)
            bpu_pkg::FMT_1BPP: db = (w_ext + bpu_pkg::DB_W'(7)) >> 3;
            bpu_pkg::FMT_4BPP: db = (w_ext + bpu_pkg::DB_W'(1)) >> 1;
            bpu_pkg::FMT_8BPP: db = w_ext;
            default:           db = w_ext + (w_ext << 1);
        endcase
        padded = (db + bpu_pkg::DB_W'(3)) & ~bpu_pkg::DB_W'(3);
    end

    // Position compares.
    always_comb begin
        is_pix   = (r_kind == bpu_pkg::KIND_PIXEL);
        active   = ({1'b0, r_rbc} < db);
        col_lt_w = (r_col < w);
        col_inc  = r_col + bpu_pkg::DIM_W'(1);
        col_end  = (col_inc >= w);
        rbc_inc  = {1'b0, r_rbc} + bpu_pkg::DB_W'(1);
        row_end  = (rbc_inc >= padded);
        row_inc  = {1'b0, r_row} + bpu_pkg::DIM_W'(1);
        row_wrap = (row_inc >= h);
        eoi      = ({1'b0, r_row} >= (h - bpu_pkg::DIM_W'(1)))
                   && (r_col == (w - bpu_pkg::DIM_W'(1)));
    end

    // Pick the pixel of this cycle and decide whether the beat finishes.
    always_comb begin
        idx      = r_byte;
        per_last = 1'b1;
        emit     = 1'b0;
        done     = 1'b1;
        if (is_pix) begin
            case (i_fmt)
                bpu_pkg::FMT_1BPP: begin
                    idx      = {7'd0, r_byte[3'd7 - r_sub]};
                    per_last = (r_sub == 3'd7);
                end
                bpu_pkg::FMT_4BPP: begin
                    idx      = r_sub[0] ? {4'd0, r_byte[3:0]} : {4'd0, r_byte[7:4]};
                    per_last = r_sub[0];
                end
                default: begin
                    idx      = r_byte;
                    per_last = 1'b1;
                end
            endcase
            if (i_fmt == bpu_pkg::FMT_24BPP) begin
                emit = active && (r_phase == 2'd2) && col_lt_w;
                done = 1'b1;
            end else begin
                emit = active && col_lt_w;
                done = !active || !col_lt_w || per_last || col_end;
            end
        end
    end

    // Handshake with the input channel and the next stage.
    assign step       = r_s1_valid && i_s2_free;
    assign o_in_stall = r_s1_valid && !(step && done);
    assign accept     = i_in_valid && !o_in_stall;

    // Counter and byte-gathering updates.
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_rbc   = r_rbc;
        n_phase = r_phase;
        n_blue  = r_blue;
        n_green = r_green;
        if (step && is_pix) begin
            if (emit) begin
                n_col = col_inc;
            end
            if (i_fmt == bpu_pkg::FMT_24BPP && active) begin
                case (r_phase)
                    2'd0: begin
                        n_blue  = r_byte;
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        n_green = r_byte;
                        n_phase = 2'd2;
                    end
                    default: n_phase = 2'd0;
                endcase
            end
            if (done) begin
                if (row_end) begin
                    n_rbc   = '0;
                    n_col   = '0;
                    n_phase = 2'd0;
                    n_row   = row_wrap ? '0 : row_inc[bpu_pkg::POS_W-1:0];
                end else begin
                    n_rbc = rbc_inc[bpu_pkg::RBC_W-1:0];
                end
            end
        end
    end

    // Beat holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (step && done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_byte <= i_data_byte;
            r_eidx <= i_entry_index;
            r_er   <= i_entry_red;
            r_eg   <= i_entry_green;
            r_eb   <= i_entry_blue;
            r_sub  <= 3'd0;
        end else if (step) begin
            r_sub  <= r_sub + 3'd1;
        end
    end

    // Row position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_rbc   <= '0;
            r_phase <= 2'd0;
            r_blue  <= '0;
            r_green <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_rbc   <= n_rbc;
            r_phase <= n_phase;
            r_blue  <= n_blue;
            r_green <= n_green;
        end
    end

    // Pixel request and palette accesses.
    always_comb begin
        o_req_valid     = step && is_pix && emit;
        o_req.direct    = (i_fmt == bpu_pkg::FMT_24BPP);
        o_req.in_range  = ({1'b0, idx} < 9'(PALETTE_DEPTH));
        o_req.rgb       = {r_byte, r_green, r_blue};
        o_req.col       = r_col[bpu_pkg::POS_W-1:0];
        o_req.row       = r_row;
        o_req.last      = done;
        o_req.eoi       = eoi;
        o_rd_addr       = idx[AW-1:0];
        o_wr_en         = step && !is_pix && ({1'b0, r_eidx} < 9'(PALETTE_DEPTH));
        o_wr_addr       = r_eidx[AW-1:0];
        o_wr_data       = {r_er, r_eg, r_eb};
    end

endmodule

// ===== sv/bpu_out.sv =====
// ----------------------------------------------------------------------------
// BMP unpacker output stage
// Pairs each pixel with its palette read data and holds the result beat
// in an output register.
// ----------------------------------------------------------------------------
module bpu_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  bpu_pkg::t_pix_req         i_req,
    input  logic [bpu_pkg::RGB_W-1:0] i_rd_data,
    output logic                      o_s2_free,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic [bpu_pkg::POS_W-1:0] o_column,
    output logic [bpu_pkg::POS_W-1:0] o_row,
    output logic                      o_last_of_byte,
    output logic                      o_end_of_image
);

    logic                      r_s2_valid;
    bpu_pkg::t_pix_req         r_s2;
    logic                      r_out_valid;
    logic [bpu_pkg::RGB_W-1:0] r_rgb;
    logic [bpu_pkg::POS_W-1:0] r_col;
    logic [bpu_pkg::POS_W-1:0] r_row;
    logic                      r_last;
    logic                      r_eoi;
    logic                      out_free;
    logic [bpu_pkg::RGB_W-1:0] rgb_sel;

    // Flow control between read stage and output register.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_s2_free = !r_s2_valid || out_free;

    // Direct pixels bypass the palette; indexes past the store read as black.
    always_comb begin
        if (r_s2.direct) begin
            rgb_sel = r_s2.rgb;
        end else if (r_s2.in_range) begin
            rgb_sel = i_rd_data;
        end else begin
            rgb_sel = '0;
        end
    end

    // Read stage, aligned with the palette read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_s2_free) begin
            r_s2_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s2_free) begin
            r_s2 <= i_req;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_rgb  <= rgb_sel;
            r_col  <= r_s2.col;
            r_row  <= r_s2.row;
            r_last <= r_s2.last;
            r_eoi  <= r_s2.eoi;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_rgb[23:16];
    assign o_green        = r_rgb[15:8];
    assign o_blue         = r_rgb[7:0];
    assign o_column       = r_col;
    assign o_row          = r_row;
    assign o_last_of_byte = r_last;
    assign o_end_of_image = r_eoi;

endmodule

// ===== sv/bmp_pixel_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// BMP pixel unpacker top level
// Path: each pixel goes from the held beat through the read stage, which is
// registered with its palette read, to the output register, in byte order.
// Rate: one beat per cycle in 8-bit and 24-bit modes unless stalled; a 4-bit
// beat gives up to two pixels and a 1-bit beat up to eight, one read each.
// Reset: synchronous, active low; counters clear, format 8-bit, 1 by 1 image.
// The palette store is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker_unit #(
    parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [bpu_pkg::DIM_W-1:0] i_cfg_data,
    // Input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [7:0]                i_data_byte,
    input  logic [7:0]                i_entry_index,
    input  logic [7:0]                i_entry_red,
    input  logic [7:0]                i_entry_green,
    input  logic [7:0]                i_entry_blue,
    // Output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic [bpu_pkg::POS_W-1:0] o_column,
    output logic [bpu_pkg::POS_W-1:0] o_row,
    output logic                      o_last_of_byte,
    output logic                      o_end_of_image
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    bpu_pkg::t_fmt             r_fmt;
    logic [bpu_pkg::DIM_W-1:0] r_width;
    logic [bpu_pkg::DIM_W-1:0] r_height;

    logic                      req_valid;
    bpu_pkg::t_pix_req         req;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [bpu_pkg::RGB_W-1:0] wr_data;
    logic [bpu_pkg::RGB_W-1:0] rd_data;
    logic                      s2_free;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= bpu_pkg::FMT_8BPP;
            r_width  <= bpu_pkg::DIM_W'(1);
            r_height <= bpu_pkg::DIM_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpu_pkg::CFG_FORMAT: r_fmt    <= bpu_pkg::t_fmt'(i_cfg_data[1:0]);
                bpu_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                bpu_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Beat unpacking and row tracking.
    bpu_unpack #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fmt         (r_fmt),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .i_entry_index (i_entry_index),
        .i_entry_red   (i_entry_red),
        .i_entry_green (i_entry_green),
        .i_entry_blue  (i_entry_blue),
        .i_s2_free     (s2_free),
        .o_req_valid   (req_valid),
        .o_req         (req),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    // Palette store.
    bpu_ram #(
        .WIDTH(bpu_pkg::RGB_W),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (req_valid),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Read alignment and output register.
    bpu_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .i_req          (req),
        .i_rd_data      (rd_data),
        .o_s2_free      (s2_free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_column       (o_column),
        .o_row          (o_row),
        .o_last_of_byte (o_last_of_byte),
        .o_end_of_image (o_end_of_image)
    );

`ifndef ASSERT_OFF
    // The final pixel of an image always closes the beat that made it.
    a_eoi_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_image |-> o_last_of_byte)
        else $error("end of image on a pixel that is not last of its beat");

    // No result beat is presented right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid directly after reset");

    // A palette write and a palette read never share a cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && req_valid))
        else $error("palette read and write in the same cycle");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the BMP pixel unpacker
// Drives palette writes and pixel-array bytes into bmp_pixel_unpacker_unit in
// all four pixel formats and compares every output pixel with an in-bench
// decoder. The run covers short directed streams, a saturated-width row, long
// output backpressure and randomized traffic under several idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         LIMIT_NS     = 5_000_000;
    localparam int         TAIL_CYCLES  = 12;
    localparam int         MAX_SHOWN    = 10;
    localparam int         RAND_PHASES  = 4;
    localparam int         PHASE_ITEMS  = 45;
    localparam int         HOLD_CYCLES  = 200;
    localparam logic [1:0] CFG_SPARE    = 2'd3;   // index with no register behind it

    // One output pixel as the decoder expects it.
    typedef struct packed {
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic [bpu_pkg::POS_W-1:0] column;
        logic [bpu_pkg::POS_W-1:0] row;
        logic                      last;
        logic                      eoi;
    } t_pixel;

    // Ports; the inputs are driven to known values from time zero.
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index   = '0;
    logic [bpu_pkg::DIM_W-1:0] i_cfg_data    = '0;
    logic                      i_in_valid    = 1'b0;
    logic                      o_in_stall;
    logic                      i_kind        = bpu_pkg::KIND_PALETTE;
    logic [7:0]                i_data_byte   = '0;
    logic [7:0]                i_entry_index = '0;
    logic [7:0]                i_entry_red   = '0;
    logic [7:0]                i_entry_green = '0;
    logic [7:0]                i_entry_blue  = '0;
    logic                      o_out_valid;
    logic                      i_out_stall   = 1'b0;
    logic [7:0]                o_red;
    logic [7:0]                o_green;
    logic [7:0]                o_blue;
    logic [bpu_pkg::POS_W-1:0] o_column;
    logic [bpu_pkg::POS_W-1:0] o_row;
    logic                      o_last_of_byte;
    logic                      o_end_of_image;

    // Decoder state and its copy of the registers.
    bpu_pkg::t_fmt             fmt_q     = bpu_pkg::FMT_8BPP;
    logic [bpu_pkg::DIM_W-1:0] width_q   = bpu_pkg::DIM_W'(1);
    logic [bpu_pkg::DIM_W-1:0] height_q  = bpu_pkg::DIM_W'(1);
    logic [23:0]               palette_q [bpu_pkg::PALETTE_DEPTH];
    int unsigned               col_cnt   = 0;
    int unsigned               row_cnt   = 0;
    int unsigned               row_bytes = 0;
    int unsigned               bgr_phase = 0;
    logic [15:0]               held_bg   = '0;
    t_pixel                    pending_pix [$];

    // Entries the sender has already queued a write for.
    bit                        pal_loaded [bpu_pkg::PALETTE_DEPTH];

    // Traffic shaping.
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               hold_len  = 0;
    int               hold_gen  = 0;
    int               hold_ack  = 0;
    int               hold_cnt  = 0;
    int               idle_mix  [4] = '{0, 52, 0, 33};
    int               stall_mix [4] = '{0, 0, 52, 33};

    // Bookkeeping.
    int               err_count    = 0;
    int               shown_count  = 0;
    int               beats_taken  = 0;
    int               entries_sent = 0;
    int               pix_checked  = 0;
    int               cfg_writes   = 0;

    bmp_pixel_unpacker_unit u_dut (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    initial begin
        #(LIMIT_NS);
        $display("bmp_pixel_unpacker_unit verification failed");
        $finish;
    end

    // Zero counts as one, anything above the limit saturates.
    function automatic int unsigned eff_dim(logic [bpu_pkg::DIM_W-1:0] v,
                                            int unsigned lim);
        int unsigned r;
        r = v;
        if (r == 0) begin
            r = 1;
        end else if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

    function automatic t_pixel make_pixel(logic [23:0] color, int unsigned w,
                                          int unsigned h);
        t_pixel p;
        p.red    = color[23:16];
        p.green  = color[15:8];
        p.blue   = color[7:0];
        p.column = col_cnt[bpu_pkg::POS_W-1:0];
        p.row    = row_cnt[bpu_pkg::POS_W-1:0];
        p.last   = 1'b0;
        p.eoi    = (row_cnt >= h - 1) && (col_cnt == w - 1);
        return p;
    endfunction

    // Decode one accepted beat and queue the pixels it yields.
    function automatic void decode_beat(logic kind, logic [7:0] dbyte, logic [7:0] idx,
                                        logic [23:0] rgb);
        int unsigned w, h, bpp, per, mask, sh, data_len, pad_len, n;
        logic [7:0]  pidx;
        t_pixel      found [8];
        if (kind == bpu_pkg::KIND_PALETTE) begin
            palette_q[idx] = rgb;
            return;
        end
        w = eff_dim(width_q, bpu_pkg::MAX_WIDTH);
        h = eff_dim(height_q, bpu_pkg::MAX_HEIGHT);
        case (fmt_q)
            bpu_pkg::FMT_1BPP: bpp = 1;
            bpu_pkg::FMT_4BPP: bpp = 4;
            bpu_pkg::FMT_8BPP: bpp = 8;
            default:           bpp = 24;
        endcase
        data_len = (w * bpp + 7) / 8;
        pad_len  = (data_len + 3) & ~32'd3;
        n = 0;
        // Only bytes inside the data part of a row make pixels.
        if (row_bytes < data_len) begin
            if (fmt_q == bpu_pkg::FMT_24BPP) begin
                // Blue, green, then red completes the pixel.
                if (bgr_phase == 0) begin
                    held_bg   = {dbyte, 8'h00};
                    bgr_phase = 1;
                end else if (bgr_phase == 1) begin
                    held_bg[7:0] = dbyte;
                    bgr_phase    = 2;
                end else begin
                    if (col_cnt < w) begin
                        found[n] = make_pixel({dbyte, held_bg[7:0], held_bg[15:8]}, w, h);
                        n++;
                        col_cnt++;
                    end
                    bgr_phase = 0;
                end
            end else begin
                // Indices come out most significant first.
                per  = 8 / bpp;
                mask = (1 << bpp) - 1;
                for (int i = 0; i < per; i++) begin
                    if (col_cnt < w) begin
                        sh       = 8 - bpp * (i + 1);
                        pidx     = 8'((dbyte >> sh) & mask);
                        found[n] = make_pixel(palette_q[pidx], w, h);
                        n++;
                        col_cnt++;
                    end
                end
            end
            if (n > 0) begin
                found[n-1].last = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
                pending_pix.push_back(found[i]);
            end
        end
        // Row end once the padded length is reached.
        row_bytes++;
        if (row_bytes >= pad_len) begin
            row_bytes = 0;
            col_cnt   = 0;
            bgr_phase = 0;
            if (row_cnt + 1 >= h) begin
                row_cnt = 0;
            end else begin
                row_cnt++;
            end
        end
    endfunction

    // Compare one output beat with the oldest expected pixel.
    function automatic void check_pixel();
        t_pixel seen, want;
        seen = {o_red, o_green, o_blue, o_column, o_row, o_last_of_byte, o_end_of_image};
        if (pending_pix.size() == 0) begin
            err_count++;
            if (shown_count < MAX_SHOWN) begin
                $display("ERROR %0t: unexpected pixel rgb=%h%h%h col=%0d row=%0d",
                         $time, seen.red, seen.green, seen.blue, seen.column, seen.row);
            end
            shown_count++;
            return;
        end
        want = pending_pix.pop_front();
        pix_checked++;
        if (seen.red !== want.red || seen.green !== want.green ||
            seen.blue !== want.blue || seen.column !== want.column ||
            seen.row !== want.row || seen.last !== want.last || seen.eoi !== want.eoi) begin
            err_count++;
            if (shown_count < MAX_SHOWN) begin
                $display("ERROR %0t: expected rgb=%h%h%h col=%0d row=%0d last=%b eoi=%b",
                         $time, want.red, want.green, want.blue, want.column, want.row,
                         want.last, want.eoi);
                $display("         actual   rgb=%h%h%h col=%0d row=%0d last=%b eoi=%b",
                         seen.red, seen.green, seen.blue, seen.column, seen.row,
                         seen.last, seen.eoi);
            end
            shown_count++;
        end
    endfunction

    // Watch all three channels; register and input beats feed the decoder.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bpu_pkg::CFG_FORMAT: fmt_q    = bpu_pkg::t_fmt'(i_cfg_data[1:0]);
                    bpu_pkg::CFG_WIDTH:  width_q  = i_cfg_data;
                    bpu_pkg::CFG_HEIGHT: height_q = i_cfg_data;
                    default:             ;
                endcase
                cfg_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                decode_beat(i_kind, i_data_byte, i_entry_index,
                            {i_entry_red, i_entry_green, i_entry_blue});
                beats_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                check_pixel();
            end
        end
    end

    // Output stall: a requested long hold-off first, otherwise random.
    always @(negedge i_clk) begin
        if (hold_gen != hold_ack) begin
            hold_ack = hold_gen;
            hold_cnt = hold_len;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one beat after a random idle gap and wait until it is taken.
    task automatic send_beat(logic kind, logic [7:0] dbyte, logic [7:0] idx,
                             logic [23:0] rgb);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_kind        <= kind;
        i_data_byte   <= dbyte;
        i_entry_index <= idx;
        i_entry_red   <= rgb[23:16];
        i_entry_green <= rgb[15:8];
        i_entry_blue  <= rgb[7:0];
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_entry(logic [7:0] idx, logic [23:0] rgb);
        pal_loaded[idx] = 1'b1;
        entries_sent++;
        send_beat(bpu_pkg::KIND_PALETTE, 8'($urandom), idx, rgb);
    endtask

    // A pixel byte; any palette entry it could look up gets written first.
    task automatic send_pixel(logic [7:0] dbyte);
        logic [7:0] need [8];
        int         cnt;
        cnt = 0;
        case (fmt_q)
            bpu_pkg::FMT_1BPP: begin
                for (int i = 0; i < 8; i++) begin
                    need[i] = {7'b0, dbyte[7-i]};
                end
                cnt = 8;
            end
            bpu_pkg::FMT_4BPP: begin
                need[0] = {4'b0, dbyte[7:4]};
                need[1] = {4'b0, dbyte[3:0]};
                cnt = 2;
            end
            bpu_pkg::FMT_8BPP: begin
                need[0] = dbyte;
                cnt = 1;
            end
            default: cnt = 0;
        endcase
        for (int i = 0; i < cnt; i++) begin
            if (!pal_loaded[need[i]]) begin
                send_entry(need[i], 24'($urandom));
            end
        end
        send_beat(bpu_pkg::KIND_PIXEL, dbyte, 8'($urandom), 24'($urandom));
    endtask

    // Drop valid, wait for every expected pixel, then let the pipe empty.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(logic [1:0] idx, logic [bpu_pkg::DIM_W-1:0] val);
        settle();
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(bpu_pkg::t_fmt fmt, logic [bpu_pkg::DIM_W-1:0] w,
                              logic [bpu_pkg::DIM_W-1:0] h);
        write_reg(bpu_pkg::CFG_FORMAT, bpu_pkg::DIM_W'(fmt));
        write_reg(bpu_pkg::CFG_WIDTH, w);
        write_reg(bpu_pkg::CFG_HEIGHT, h);
    endtask

    // Power-on settings: 8-bit, 1 by 1, so each 4-byte row gives one pixel.
    task automatic test_power_on_defaults();
        send_entry(8'h00, 24'h000000);
        send_entry(8'hFF, 24'hFFFFFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h5A);
        send_pixel(8'hA5);
    endtask

    // 1-bit: a full byte, a byte cut at the width, then row padding.
    task automatic test_one_bit();
        set_config(bpu_pkg::FMT_1BPP, bpu_pkg::DIM_W'(10), bpu_pkg::DIM_W'(1));
        send_pixel(8'hA5);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h3C);
    endtask

    // 4-bit: odd width drops the low nibble of the second byte; two rows.
    task automatic test_four_bit();
        set_config(bpu_pkg::FMT_4BPP, bpu_pkg::DIM_W'(3), bpu_pkg::DIM_W'(2));
        send_pixel(8'h12);
        send_pixel(8'hF0);
        send_pixel(8'h77);
        send_pixel(8'h88);
        send_pixel(8'h0F);
        send_pixel(8'h80);
        send_pixel(8'h00);
        send_pixel(8'hFF);
    endtask

    // 24-bit: one pixel per row, the fourth byte of each row is padding.
    task automatic test_direct_bgr();
        set_config(bpu_pkg::FMT_24BPP, bpu_pkg::DIM_W'(1), bpu_pkg::DIM_W'(2));
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        send_pixel(8'hFF);
        send_pixel(8'h12);
        send_pixel(8'h34);
        send_pixel(8'h56);
        send_pixel(8'h00);
    endtask

    // Zero dimensions count as one; a write to the spare index changes nothing.
    task automatic test_dim_limits();
        set_config(bpu_pkg::FMT_8BPP, '0, '0);
        send_pixel(8'h01);
        send_pixel(8'hFE);
        send_pixel(8'h02);
        send_pixel(8'h03);
        write_reg(CFG_SPARE, '1);
        send_pixel(8'h7F);
        send_pixel(8'h80);
        send_pixel(8'h04);
        send_pixel(8'h05);
    endtask

    // Saturated width in 1-bit mode: the start of a 4096-pixel row.
    task automatic test_widest_row();
        set_config(bpu_pkg::FMT_1BPP, '1, '0);
        repeat (32) send_pixel(8'($urandom));
    endtask

    // Long output hold-off fills the block, then the sender waits for a drain.
    task automatic test_backpressure();
        set_config(bpu_pkg::FMT_8BPP, bpu_pkg::DIM_W'(16), '1);
        @(posedge i_clk);
        hold_len = HOLD_CYCLES;
        hold_gen++;
        repeat (24) send_pixel(8'($urandom));
        settle();
        repeat (8) send_pixel(8'($urandom));
    endtask

    // Random streams under each idle mix; phases end mid-row on purpose.
    task automatic test_random_traffic();
        bpu_pkg::t_fmt             fmt;
        logic [bpu_pkg::DIM_W-1:0] w, h;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            fmt = bpu_pkg::t_fmt'(2'($urandom_range(3)));
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0:       w = '0;
                    1:       w = '1;
                    2:       w = bpu_pkg::DIM_W'(bpu_pkg::MAX_WIDTH);
                    default: w = bpu_pkg::DIM_W'(bpu_pkg::MAX_WIDTH + 1);
                endcase
            end else begin
                w = bpu_pkg::DIM_W'($urandom_range(1, 24));
            end
            h = ($urandom_range(9) == 0) ? '1 : bpu_pkg::DIM_W'($urandom_range(0, 4));
            set_config(fmt, w, h);
            idle_pct  = idle_mix[ph % 4];
            stall_pct = stall_mix[ph % 4];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 8) begin
                    send_entry(8'($urandom), 24'($urandom));
                end else begin
                    send_pixel(8'($urandom));
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_power_on_defaults();
        test_one_bit();
        test_four_bit();
        test_direct_bgr();
        test_dim_limits();
        test_widest_row();
        test_backpressure();
        test_random_traffic();
        settle();
        $display("Run covered %0d input beats (%0d palette writes) and %0d register writes",
                 beats_taken, entries_sent, cfg_writes);
        $display("over all four formats; %0d pixels checked, %0d mismatches.",
                 pix_checked, err_count);
        if (err_count == 0) begin
            $display("bmp_pixel_unpacker_unit verification clean");
        end else begin
            $display("bmp_pixel_unpacker_unit verification failed");
        end
        $finish;
    end

endmodule
